FILE: sv/rsc_pkg.sv
package rsc_pkg;

	// Register map: the register index is address bit 2.
	localparam int AddrWidth = 3;
	localparam int DataWidth = 32;

	typedef enum logic {
		REG_FILL_COLOR = 1'b0,
		REG_BLEND_MODE = 1'b1
	} reg_index_t;

	typedef enum logic {
		MODE_SRC_OVER = 1'b0,
		MODE_CLEAR    = 1'b1
	} blend_mode_t;

	localparam logic [7:0] BYTE_MAX = 8'hFF;

	// Datapath cfg; user keeps it fixed with pixels in flight (unchecked).
	typedef struct packed {
		logic [31:0] src_color;   // premultiplied fill color
		logic [7:0]  fill_alpha;  // straight fill alpha
		blend_mode_t mode;
	} cfg_t;

	// One byte lane scaled by a factor: (c * (a + 1)) >> 8.
	function automatic logic [7:0] scale_byte(logic [7:0] c, logic [7:0] a);
		logic [16:0] p;
		p = 17'(c) * 17'({1'b0, a} + 9'd1);
		return p[15:8];
	endfunction

	// All four byte lanes scaled by the same factor.
	function automatic logic [31:0] scale_lanes(logic [31:0] x, logic [7:0] a);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			r[8*i +: 8] = scale_byte(x[8*i +: 8], a);
		end
		return r;
	endfunction

	// Color lanes scaled by alpha, alpha lane kept.
	function automatic logic [31:0] premultiply(logic [31:0] c);
		logic [31:0] s;
		s = scale_lanes(c, c[31:24]);
		return {c[31:24], s[23:0]};
	endfunction

endpackage

FILE: sv/rsc_regs.sv
module rsc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rsc_pkg::AddrWidth-1:0] paddr,
	input  logic [rsc_pkg::DataWidth-1:0] pwdata,
	output logic [rsc_pkg::DataWidth-1:0] prdata,
	output logic                         pready,
	output rsc_pkg::cfg_t                cfg
);
	import rsc_pkg::*;

	logic [31:0] fill_color_q;
	logic [31:0] src_color_q;
	blend_mode_t blend_mode_q;
	reg_index_t  reg_sel;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; the premultiplied color is formed once per fill color write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
			src_color_q  <= '0;
			blend_mode_q <= MODE_SRC_OVER;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FILL_COLOR: begin
					fill_color_q <= pwdata;
					src_color_q  <= premultiply(pwdata);
				end
				REG_BLEND_MODE: begin
					blend_mode_q <= blend_mode_t'(pwdata[0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (reg_sel)
			REG_FILL_COLOR: prdata = fill_color_q;
			REG_BLEND_MODE: prdata = {31'b0, blend_mode_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.src_color  = src_color_q;
	assign cfg.fill_alpha = fill_color_q[31:24];
	assign cfg.mode       = blend_mode_q;

endmodule

FILE: sv/rsc_datapath.sv
module rsc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  rsc_pkg::cfg_t cfg,
	input  logic          pixel_valid,
	output logic          pixel_stall,
	input  logic [31:0]   dest_pixel,
	input  logic [7:0]    coverage,
	input  logic          span_end,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [31:0]   result_pixel,
	output logic          span_end_out
);
	import rsc_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        ld_s1, ld_s2, ld_s3, ld_s4;

	logic [31:0] dest_s1;
	logic [7:0]  cov_s1;
	logic        end_s1;

	logic [31:0] src_s2;
	logic [31:0] dest_s2;
	logic [7:0]  clr_alpha_s2;
	logic        end_s2;

	logic [31:0] src_s3;
	logic [31:0] dscl_s3;
	logic [31:0] dest_s3;
	logic [7:0]  clr_alpha_s3;
	logic        end_s3;

	logic [31:0] res_s4;
	logic        end_s4;

	logic [15:0] clr_prod;
	logic [7:0]  dest_gain;

	// A stage takes a new request when it is empty or its content moves on.
	assign ld_s4 = !v_s4 || !result_stall;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign pixel_stall = !ld_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= pixel_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the request.
	always_ff @(posedge clk) begin
		if (ld_s1 && pixel_valid) begin
			dest_s1 <= dest_pixel;
			cov_s1  <= coverage;
			end_s1  <= span_end;
		end
	end

	// Stage 2: source scaled by coverage, and the clear-mode alpha.
	assign clr_prod = 16'(cfg.fill_alpha) * 16'(cov_s1);

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			src_s2       <= (cov_s1 == BYTE_MAX) ? cfg.src_color
			                                     : scale_lanes(cfg.src_color, cov_s1);
			dest_s2      <= dest_s1;
			clr_alpha_s2 <= BYTE_MAX - clr_prod[15:8];
			end_s2       <= end_s1;
		end
	end

	// Stage 3: destination scaled by the inverse source alpha.
	assign dest_gain = BYTE_MAX - src_s2[31:24];

	always_ff @(posedge clk) begin
		if (ld_s3 && v_s2) begin
			src_s3       <= src_s2;
			dscl_s3      <= scale_lanes(dest_s2, dest_gain);
			dest_s3      <= dest_s2;
			clr_alpha_s3 <= clr_alpha_s2;
			end_s3       <= end_s2;
		end
	end

	// Stage 4: sum or alpha rewrite into the output register.
	always_ff @(posedge clk) begin
		if (ld_s4 && v_s3) begin
			case (cfg.mode)
				MODE_CLEAR: res_s4 <= {clr_alpha_s3, dest_s3[23:0]};
				default:    res_s4 <= src_s3 + dscl_s3;
			endcase
			end_s4 <= end_s3;
		end
	end

	assign result_valid = v_s4;
	assign result_pixel = res_s4;
	assign span_end_out = end_s4;

	// The input stalls only when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall == (v_s1 && v_s2 && v_s3 && v_s4 && result_stall))
		else $error("input stall does not match pipeline occupancy");

	// A held first stage keeps its request.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ld_s2) |=> (v_s1 && $stable(dest_s1) && $stable(cov_s1)))
		else $error("stage 1 request lost while held");

	// A held second stage keeps its partial result.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ld_s3) |=> (v_s2 && $stable(src_s2) && $stable(clr_alpha_s2)))
		else $error("stage 2 request lost while held");

	// A request moving out of stage 3 always lands in the output register.
	a_s3_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ld_s4) |=> v_s4)
		else $error("stage 3 request dropped");

endmodule

FILE: sv/rgba_span_compositor.sv
// RGBA8 span compositor: blends the configured fill color into a stream of
// destination pixels, one pixel request per clock while pixel_stall is low.
// Pixel channel: pixel_valid/pixel_stall with dest_pixel, coverage and
// span_end; a request is taken at an edge with valid high and stall low.
// Result channel: result_valid/result_stall with result_pixel and
// span_end_out, the span marker copied through unchanged.
// The datapath has four register stages: capture, source scaling,
// destination scaling and the output register. It takes one pixel per clock
// while pixel_stall is low, with byte-lane multipliers in the stages.
// When the receiver stalls, the output register holds its result and the
// earlier stages keep filling until all four are full; only then does
// pixel_stall rise. Nothing is dropped or repeated.
// Reset clears all stage valid bits; fill_color and blend_mode reset to 0.
// Configuration is written over the APB port (fill_color at 0x0, blend_mode
// at 0x4). The user writes it only with no pixel in flight; not enforced.
module rgba_span_compositor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsc_pkg::AddrWidth-1:0] paddr,
	input  logic [rsc_pkg::DataWidth-1:0] pwdata,
	output logic [rsc_pkg::DataWidth-1:0] prdata,
	output logic                          pready,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic [31:0]                   dest_pixel,
	input  logic [7:0]                    coverage,
	input  logic                          span_end,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [31:0]                   result_pixel,
	output logic                          span_end_out
);
	import rsc_pkg::*;

	cfg_t cfg;

	// Configuration registers.
	rsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Compositing pipeline.
	rsc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.dest_pixel   (dest_pixel),
		.coverage     (coverage),
		.span_end     (span_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_pixel (result_pixel),
		.span_end_out (span_end_out)
	);

endmodule

FILE: tb/sv/tb_rgba_span_compositor.sv
`timescale 1ns / 100ps

module tb_rgba_span_compositor;
	import rsc_pkg::*;

	localparam int RANDOM_ITEMS = 440;
	localparam int CALM_TAIL    = 60;
	localparam int LONG_HOLD    = 40;
	localparam int STUCK_LIMIT  = 2000;

	// One row of the directed table. Where known is set, want is the result
	// read straight off the blend equations; otherwise the predictor decides.
	typedef struct packed {
		logic        set_cfg;
		logic [31:0] fill;
		blend_mode_t mode;
		logic [31:0] dest;
		logic [7:0]  cov;
		logic        last;
		logic        known;
		logic [31:0] want;
	} pixel_case_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        last;
	} pixel_result_t;

	localparam int DIRECTED_ROWS = 18;
	localparam pixel_case_t DIRECTED_CASES [DIRECTED_ROWS] = '{
		// Reset settings: a transparent black fill leaves the pixel as it is.
		'{1'b0, 32'h0000_0000, MODE_SRC_OVER, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 32'h0000_0000},
		'{1'b0, 32'h0000_0000, MODE_SRC_OVER, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 32'h0000_0000, MODE_SRC_OVER, 32'h1234_5678, 8'h80, 1'b0, 1'b1, 32'h1234_5678},
		// Opaque white: full coverage replaces, zero coverage keeps the pixel.
		'{1'b1, 32'hFFFF_FFFF, MODE_SRC_OVER, 32'h0000_0000, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 32'hFFFF_FFFF, MODE_SRC_OVER, 32'hA5A5_A5A5, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 32'hFFFF_FFFF, MODE_SRC_OVER, 32'h5A5A_5A5A, 8'h00, 1'b0, 1'b1, 32'h5A5A_5A5A},
		'{1'b0, 32'hFFFF_FFFF, MODE_SRC_OVER, 32'h3C96_E10F, 8'h7F, 1'b0, 1'b0, 32'h0000_0000},
		// Half alpha fill around the full coverage boundary.
		'{1'b1, 32'h80FF_4020, MODE_SRC_OVER, 32'h0000_0000, 8'hFF, 1'b0, 1'b0, 32'h0000_0000},
		'{1'b0, 32'h80FF_4020, MODE_SRC_OVER, 32'hFFFF_FFFF, 8'hFE, 1'b0, 1'b0, 32'h0000_0000},
		'{1'b0, 32'h80FF_4020, MODE_SRC_OVER, 32'h8080_8080, 8'h01, 1'b1, 1'b0, 32'h0000_0000},
		// Zero fill alpha premultiplies the color away.
		'{1'b1, 32'h00FF_FFFF, MODE_SRC_OVER, 32'hC0FF_EE11, 8'hFF, 1'b0, 1'b1, 32'hC0FF_EE11},
		// Clear mode rewrites only the alpha byte.
		'{1'b1, 32'hFFAB_CDEF, MODE_CLEAR,    32'h1122_3344, 8'hFF, 1'b0, 1'b1, 32'h0122_3344},
		'{1'b0, 32'hFFAB_CDEF, MODE_CLEAR,    32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 32'hFFAB_CDEF, MODE_CLEAR,    32'h0000_0000, 8'h80, 1'b0, 1'b1, 32'h8000_0000},
		'{1'b1, 32'h0012_3456, MODE_CLEAR,    32'h8765_4321, 8'hFF, 1'b0, 1'b1, 32'hFF65_4321},
		'{1'b1, 32'h7F80_8080, MODE_CLEAR,    32'hDEAD_BEEF, 8'hC3, 1'b1, 1'b0, 32'h0000_0000},
		// Nearly transparent fill back in source-over.
		'{1'b1, 32'h0102_0304, MODE_SRC_OVER, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 32'h0000_0000},
		'{1'b0, 32'h0102_0304, MODE_SRC_OVER, 32'h0000_0000, 8'h80, 1'b1, 1'b0, 32'h0000_0000}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	logic                 pixel_valid;
	logic                 pixel_stall;
	logic [31:0]          dest_pixel;
	logic [7:0]           coverage;
	logic                 span_end;
	logic                 result_valid;
	logic                 result_stall;
	logic [31:0]          result_pixel;
	logic                 span_end_out;

	// Side payload that travels with each request: a typed-in expectation.
	logic        want_known;
	logic [31:0] want_pixel;

	// Shadow copy of the configuration registers.
	logic [31:0] fill_color_cfg;
	blend_mode_t blend_mode_cfg;

	pixel_result_t pending_pixels[$];
	int unsigned   pixels_sent;
	int unsigned   results_seen = 0;
	int unsigned   clear_pixels;
	int unsigned   settings_used;
	int unsigned   errors;
	int unsigned   stuck_cycles = 0;
	logic          calm;

	rgba_span_compositor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.dest_pixel  (dest_pixel),
		.coverage    (coverage),
		.span_end    (span_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_pixel(result_pixel),
		.span_end_out(span_end_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scales each byte lane by (f + 1) / 256, red/blue and green/alpha pairs at once.
	function automatic logic [31:0] lane_scale(logic [31:0] px, logic [7:0] f);
		logic [40:0] rb;
		logic [40:0] ga;
		logic [8:0]  k;
		k  = {1'b0, f} + 9'd1;
		rb = ({9'd0, px & 32'h00FF_00FF} * k) >> 8;
		ga = {9'd0, (px & 32'hFF00_FF00) >> 8} * k;
		return (rb[31:0] & 32'h00FF_00FF) | (ga[31:0] & 32'hFF00_FF00);
	endfunction

	function automatic logic [31:0] premul_rgba(logic [31:0] c);
		logic [31:0] s;
		s = lane_scale(c, c[31:24]);
		return {c[31:24], s[23:0]};
	endfunction

	// Expected write-back pixel under the current shadow configuration.
	function automatic logic [31:0] composite_pixel(logic [31:0] dest, logic [7:0] cov);
		logic [31:0] src;
		logic [7:0]  inv;
		logic [15:0] cut;
		if (blend_mode_cfg == MODE_SRC_OVER) begin
			src = premul_rgba(fill_color_cfg);
			if (cov != BYTE_MAX)
				src = lane_scale(src, cov);
			inv = BYTE_MAX - src[31:24];
			return src + lane_scale(dest, inv);
		end else begin
			cut = 16'(fill_color_cfg[31:24]) * 16'(cov);
			inv = BYTE_MAX - cut[15:8];
			return {inv, dest[23:0]};
		end
	endfunction

	// Writes both registers back to back; psel stays high between the two.
	task automatic write_config(logic [31:0] fill, logic [31:0] mode_word);
		reg_index_t idx;
		psel   <= 1'b1;
		pwrite <= 1'b1;
		for (int r = 0; r < 2; r++) begin
			idx = (r == 0) ? REG_FILL_COLOR : REG_BLEND_MODE;
			penable <= 1'b0;
			paddr   <= {idx, 2'b00};
			pwdata  <= (idx == REG_FILL_COLOR) ? fill : mode_word;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		fill_color_cfg = fill;
		blend_mode_cfg = blend_mode_t'(mode_word[0]);
		settings_used++;
	endtask

	// Offers one pixel request; returns where it is taken, or after a random pause with pixel_valid low.
	task automatic send_pixel(logic [31:0] dest, logic [7:0] cov, logic last,
			logic known, logic [31:0] want);
		pixel_valid <= 1'b1;
		dest_pixel  <= dest;
		coverage    <= cov;
		span_end    <= last;
		want_known  <= known;
		want_pixel  <= want;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		pixels_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	// Stops offering and waits until every request has its result back.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (results_seen != pixels_sent)
			@(posedge clk);
	endtask

	// Main sequence: reset, directed table, then random register settings.
	initial begin
		pixel_case_t row;
		logic [31:0] fill;
		logic [31:0] mode_word;
		logic [31:0] dest;
		logic [7:0]  cov;
		int unsigned random_sent;
		int unsigned phase_len;
		int unsigned span_left;

		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		pixel_valid <= 1'b0;
		dest_pixel  <= '0;
		coverage    <= '0;
		span_end    <= 1'b0;
		want_known  <= 1'b0;
		want_pixel  <= '0;
		calm        <= 1'b0;
		fill_color_cfg = '0;
		blend_mode_cfg = MODE_SRC_OVER;
		pixels_sent    = 0;
		clear_pixels   = 0;
		settings_used  = 1;
		errors         = 0;
		random_sent    = 0;
		span_left      = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED_CASES[i];
			if (row.set_cfg) begin
				wait_idle();
				write_config(row.fill, {31'd0, row.mode});
			end
			send_pixel(row.dest, row.cov, row.last, row.known, row.want);
		end

		while (random_sent < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: fill = 32'h0000_0000;
				1: fill = 32'hFFFF_FFFF;
				2: fill = {8'h00, 24'($urandom())};
				3: fill = {8'hFF, 24'($urandom())};
				default: fill = $urandom();
			endcase
			// Bits above the mode bit are don't-care; sometimes set them.
			mode_word = $urandom();
			if ($urandom_range(0, 1) == 0)
				mode_word[31:1] = '0;
			write_config(fill, mode_word);
			phase_len = $urandom_range(20, 60);
			for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
				// A mid-phase pause under the third setting; settings_used is past 3 here, so it never fires.
				if (settings_used == 3 && i == phase_len / 2)
					wait_idle();
				if (random_sent >= RANDOM_ITEMS - CALM_TAIL)
					calm <= 1'b1;
				case ($urandom_range(0, 7))
					0: dest = 32'h0000_0000;
					1: dest = 32'hFFFF_FFFF;
					default: dest = $urandom();
				endcase
				case ($urandom_range(0, 7))
					0, 1: cov = BYTE_MAX;
					2: cov = 8'h00;
					3: cov = ($urandom_range(0, 1) == 0) ? 8'hFE : 8'h01;
					default: cov = 8'($urandom());
				endcase
				// Spans of 1 to 16 pixels, end marker on the last one.
				if (span_left == 0)
					span_left = $urandom_range(1, 16);
				send_pixel(dest, cov, span_left == 1, 1'b0, 32'h0);
				span_left--;
				random_sent++;
			end
		end

		wait_idle();
		repeat (8)
			@(posedge clk);
		if (pending_pixels.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_pixels.size());
			errors++;
		end
		$display("Composited %0d pixels (%0d in clear mode) under %0d register settings;",
			pixels_sent, clear_pixels, settings_used);
		$display("long result stalls, a drained pipeline and span markers were included.");
		if (errors == 0)
			$display("tb_rgba_span_compositor: PASS");
		else
			$display("tb_rgba_span_compositor: FAIL");
		$finish;
	end

	// Result side stalls: short bursts, quiet stretches and long hold-offs.
	initial begin
		int unsigned held;
		int unsigned quiet;
		int unsigned next_hold;
		result_stall <= 1'b0;
		quiet     = 0;
		next_hold = 100;
		forever begin
			@(posedge clk);
			if (!calm && arst_n && results_seen >= next_hold) begin
				// The pipeline fills up behind this and pixel_stall must rise.
				result_stall <= 1'b1;
				held = 0;
				while (held < LONG_HOLD) begin
					@(posedge clk);
					held++;
				end
				result_stall <= 1'b0;
				next_hold += 180;
			end else if (calm || quiet > 0) begin
				if (quiet > 0)
					quiet--;
			end else if ($urandom_range(0, 19) == 0) begin
				quiet = $urandom_range(10, 30);
			end else if ($urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 3))
					@(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Records accepted requests and checks accepted results in order.
	always @(posedge clk) begin : pixel_monitor
		pixel_result_t want;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				want.pixel = want_known ? want_pixel : composite_pixel(dest_pixel, coverage);
				want.last  = span_end;
				pending_pixels = {pending_pixels, want};
				if (blend_mode_cfg == MODE_CLEAR)
					clear_pixels++;
			end
			if (result_valid && !result_stall) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: result %08h with no request pending", $time, result_pixel);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					if (result_pixel !== want.pixel) begin
						$display("%0t: result_pixel expected %08h, got %08h",
							$time, want.pixel, result_pixel);
						errors++;
					end
					if (span_end_out !== want.last) begin
						$display("%0t: span_end_out expected %0b, got %0b",
							$time, want.last, span_end_out);
						errors++;
					end
				end
				results_seen <= results_seen + 1;
			end
		end
	end

	// Watchdog: too long without any request or result moving.
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, STUCK_LIMIT);
			$display("tb_rgba_span_compositor: FAIL");
			$finish;
		end
	end

endmodule

FILE: files.f
sv/rsc_pkg.sv
sv/rsc_regs.sv
sv/rsc_datapath.sv
sv/rgba_span_compositor.sv
tb/sv/tb_rgba_span_compositor.sv
